FILE: rtl/sos_pkg.sv
// shared types and constants for the script opcode scanner
package sos_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SKIP_W   = 32;
    localparam int unsigned LEFT_W   = 3;
    localparam int unsigned POS_W    = 2;

    localparam logic [BYTE_W-1:0] TARGET_RESET    = 8'hBB;
    localparam logic [BYTE_W-1:0] DIRECT_PUSH_MAX = 8'h4B;
    localparam logic [BYTE_W-1:0] OPC_PUSHDATA1   = 8'h4C;
    localparam logic [BYTE_W-1:0] OPC_PUSHDATA2   = 8'h4D;
    localparam logic [BYTE_W-1:0] OPC_PUSHDATA4   = 8'h4E;

    typedef enum logic [1:0]
    {
        PHASE_OPCODE  = 2'd0,
        PHASE_LENGTH  = 2'd1,
        PHASE_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0]
    {
        VERDICT_FOUND     = 2'd0,
        VERDICT_ABSENT    = 2'd1,
        VERDICT_MALFORMED = 2'd2
    } verdict_t;

    typedef struct packed
    {
        logic     valid;
        verdict_t verdict;
    } result_t;

endpackage

FILE: rtl/script_opcode_scanner.sv
// top level of the script opcode scanner
// Scans a transaction script fed one byte per beat and tells whether the
// configured target opcode appears in opcode position. Direct pushes
// (0x00-0x4b) skip that many payload bytes; PUSHDATA1/2/4 read a 1-, 2- or
// 4-byte little-endian length and then skip that payload, so payload bytes are
// never searched. On the beat marked tlast one verdict beat leaves: 0 target
// found, 1 well formed but absent, 2 malformed (script ended inside a length
// field or payload, including a push opened on the last byte); malformed wins
// over found. All other beats produce nothing. The scan state updates in the
// cycle a beat is taken, so one byte is accepted every cycle; the verdict sits
// in an output register, and s_tready drops only while that register holds an
// untaken verdict and m_tready is low. The target opcode (reset 0xbb) is
// written on the cfg channel, which is always ready; write it only while idle.
module script_opcode_scanner
    import sos_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] script_byte
    input  logic              s_tlast,   // last_byte
    // output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [1:0] verdict, [7:2] zero
    // target opcode write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [BYTE_W-1:0] cfg_data
);

    logic [BYTE_W-1:0] target_reg;
    logic              beat_accept;
    logic              out_full;
    result_t           result;
    verdict_t          verdict;

    // target opcode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_reg <= TARGET_RESET;
        else if (cfg_valid && cfg_ready)
            target_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;

    // take a byte unless a verdict is stuck in the output register
    assign s_tready    = !out_full || m_tready;
    assign beat_accept = s_tvalid && s_tready;

    sos_scan_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .beat_accept   (beat_accept),
        .script_byte   (s_tdata),
        .last_byte     (s_tlast),
        .target_opcode (target_reg),
        .result        (result)
    );

    sos_out_reg u_out
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .result  (result),
        .take    (m_tready),
        .full    (out_full),
        .verdict (verdict)
    );

    assign m_tvalid = out_full;
    assign m_tdata  = {6'b000000, verdict};

endmodule

FILE: rtl/sos_scan_core.sv
// per-byte scan state: phase, length assembly, payload countdown, found flag
module sos_scan_core
    import sos_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              beat_accept,
    input  logic [BYTE_W-1:0] script_byte,
    input  logic              last_byte,
    input  logic [BYTE_W-1:0] target_opcode,
    output result_t           result
);

    phase_t              phase_reg, phase_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [SKIP_W-1:0]   skip_reg, skip_next;
    logic                found_reg, found_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_OPCODE;
            left_reg  <= '0;
            pos_reg   <= '0;
            skip_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            skip_reg  <= skip_next;
            found_reg <= found_next;
        end
    end

    always_comb
    begin
        logic [LEFT_W-1:0] left_dec;
        logic [SKIP_W-1:0] skip_dec;

        phase_next = phase_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        skip_next  = skip_reg;
        found_next = found_reg;
        result     = '{valid: 1'b0, verdict: VERDICT_ABSENT};
        left_dec   = (left_reg != '0) ? left_reg - LEFT_W'(1) : '0;
        skip_dec   = (skip_reg != '0) ? skip_reg - SKIP_W'(1) : '0;

        if (beat_accept)
        begin
            unique case (phase_reg)
                PHASE_LENGTH:
                begin
                    // little-endian length, one byte a beat
                    skip_next = skip_reg | (SKIP_W'(script_byte) << {pos_reg, 3'b000});
                    pos_next  = pos_reg + POS_W'(1);
                    left_next = left_dec;
                    if (left_dec == '0)
                        phase_next = (skip_next == '0) ? PHASE_OPCODE : PHASE_PAYLOAD;
                end
                PHASE_PAYLOAD:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                        phase_next = PHASE_OPCODE;
                end
                default:
                begin
                    // target check first: a target that is a push opcode starts no push
                    priority if (script_byte == target_opcode)
                        found_next = 1'b1;
                    else if (script_byte <= DIRECT_PUSH_MAX)
                    begin
                        skip_next  = SKIP_W'(script_byte);
                        left_next  = '0;
                        pos_next   = '0;
                        phase_next = (script_byte == '0) ? PHASE_OPCODE : PHASE_PAYLOAD;
                    end
                    else if (script_byte == OPC_PUSHDATA1 || script_byte == OPC_PUSHDATA2
                             || script_byte == OPC_PUSHDATA4)
                    begin
                        phase_next = PHASE_LENGTH;
                        pos_next   = '0;
                        skip_next  = '0;
                        if (script_byte == OPC_PUSHDATA1)
                            left_next = LEFT_W'(1);
                        else if (script_byte == OPC_PUSHDATA2)
                            left_next = LEFT_W'(2);
                        else
                            left_next = LEFT_W'(4);
                    end
                    else
                        phase_next = PHASE_OPCODE;
                end
            endcase

            if (last_byte)
            begin
                result.valid = 1'b1;
                if (phase_next == PHASE_LENGTH || phase_next == PHASE_PAYLOAD)
                    result.verdict = VERDICT_MALFORMED;
                else if (found_next)
                    result.verdict = VERDICT_FOUND;
                else
                    result.verdict = VERDICT_ABSENT;
                // back to reset for the next script
                phase_next = PHASE_OPCODE;
                left_next  = '0;
                pos_next   = '0;
                skip_next  = '0;
                found_next = 1'b0;
            end
        end
    end

    // length phase always has length bytes left to read
    a_length_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PHASE_LENGTH |-> left_reg != '0)
        else $error("length phase with no length bytes left");

    // payload phase always has payload left to skip
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PHASE_PAYLOAD |-> skip_reg != '0)
        else $error("payload phase with zero skip count");

    // opcode phase never holds a pending length field
    a_opcode_no_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PHASE_OPCODE |-> left_reg == '0)
        else $error("opcode phase with length bytes pending");

    // a last byte leaves the scan cleared
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        beat_accept && last_byte |=> phase_reg == PHASE_OPCODE && !found_reg
                                     && skip_reg == '0)
        else $error("scan state not cleared after last byte");

endmodule

FILE: rtl/sos_out_reg.sv
// verdict holding register toward the output stream
module sos_out_reg
    import sos_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  result_t  result,
    input  logic     take,
    output logic     full,
    output verdict_t verdict
);

    logic     valid_reg;
    verdict_t verdict_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (result.valid)
            valid_reg <= 1'b1;
        else if (take)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
            verdict_reg <= result.verdict;
    end

    assign full    = valid_reg;
    assign verdict = verdict_reg;

endmodule

FILE: sim/testbench.sv
// self-checking testbench for the script opcode scanner
`timescale 1ns / 100ps

module testbench;
    import sos_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BEATS  = 140;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int SHOW_LIMIT   = 10;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [BYTE_W-1:0] cfg_data;

    script_opcode_scanner dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] script_byte
        .s_tlast   (s_tlast),   // last_byte
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [1:0] verdict, [7:2] zero
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // scanner prediction: own copy of the scan state and the target
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] target_reg   = TARGET_RESET;
    phase_t            cur_phase    = PHASE_OPCODE;
    logic [LEFT_W-1:0] length_left  = '0;
    logic [POS_W-1:0]  length_pos   = '0;
    logic [SKIP_W-1:0] payload_left = '0;
    logic              target_seen  = 1'b0;

    // verdicts owed by the scanner, oldest first
    verdict_t verdicts_due[$];

    // one byte through the scan; returns 1 when the byte closes a script
    function automatic bit scan_script_byte(input logic [BYTE_W-1:0] b, input logic last,
                                            output verdict_t v);
        v = VERDICT_ABSENT;
        case (cur_phase)
            PHASE_LENGTH:
            begin
                // little-endian length, low byte first
                payload_left = payload_left | ({24'd0, b} << (8 * length_pos));
                length_pos   = length_pos + 2'd1;
                if (length_left != 0)
                    length_left = length_left - 3'd1;
                if (length_left == 0)
                    cur_phase = (payload_left == 0) ? PHASE_OPCODE : PHASE_PAYLOAD;
            end
            PHASE_PAYLOAD:
            begin
                // payload bytes are skipped, never searched
                if (payload_left != 0)
                    payload_left = payload_left - 32'd1;
                if (payload_left == 0)
                    cur_phase = PHASE_OPCODE;
            end
            default:
            begin
                // target match wins over any push meaning of the byte
                if (b == target_reg)
                    target_seen = 1'b1;
                else if (b <= DIRECT_PUSH_MAX)
                begin
                    payload_left = {24'd0, b};
                    length_left  = '0;
                    length_pos   = '0;
                    cur_phase    = (b == 0) ? PHASE_OPCODE : PHASE_PAYLOAD;
                end
                else if (b == OPC_PUSHDATA1 || b == OPC_PUSHDATA2 || b == OPC_PUSHDATA4)
                begin
                    cur_phase    = PHASE_LENGTH;
                    length_left  = (b == OPC_PUSHDATA1) ? 3'd1 :
                                   (b == OPC_PUSHDATA2) ? 3'd2 : 3'd4;
                    length_pos   = '0;
                    payload_left = '0;
                end
                else
                    cur_phase = PHASE_OPCODE;
            end
        endcase
        if (!last)
            return 1'b0;
        // ending inside a length field or payload beats a find
        if (cur_phase == PHASE_LENGTH || cur_phase == PHASE_PAYLOAD)
            v = VERDICT_MALFORMED;
        else if (target_seen)
            v = VERDICT_FOUND;
        cur_phase    = PHASE_OPCODE;
        length_left  = '0;
        length_pos   = '0;
        payload_left = '0;
        target_seen  = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // idling on both sides
    // ------------------------------------------------------------------
    bit no_gaps     = 1'b0;
    int beats_taken = 0;

    // mostly short gaps, a few long ones, none while no_gaps is set
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offer one byte, wait for the beat, then predict; a fixed row carries
    // its verdict typed in rather than predicted
    task automatic send_script_byte(input logic [BYTE_W-1:0] b, input logic last,
                                    input logic fixed, input verdict_t fixed_v);
        verdict_t v;
        int       gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        beats_taken++;
        if (scan_script_byte(b, last, v))
            verdicts_due.insert(verdicts_due.size(), fixed ? fixed_v : v);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // new target only once the scanner has gone quiet
    task automatic write_target(input logic [BYTE_W-1:0] value);
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        target_reg  = value;
    endtask

    // ------------------------------------------------------------------
    // script generation
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] script_bytes[$];

    // add one byte at the end of the script being built
    task automatic append_script_byte(input logic [BYTE_W-1:0] b);
        script_bytes.insert(script_bytes.size(), b);
    endtask

    // payload content, now and then holding the target to show it is skipped
    task automatic put_payload(input int n);
        for (int i = 0; i < n; i++)
            append_script_byte(($urandom_range(0, 9) == 0) ? target_reg
                                                           : 8'($urandom));
    endtask

    // one complete opcode or push
    task automatic put_wellformed_op();
        int          sel;
        logic [31:0] len;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            append_script_byte(($urandom_range(0, 3) == 0) ? target_reg
                               : 8'($urandom_range(8'h4f, 8'hff)));
        else if (sel < 55)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 75) : $urandom_range(0, 4);
            append_script_byte(len[7:0]);
            put_payload(len);
        end
        else if (sel < 70)
        begin
            len = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
            append_script_byte(OPC_PUSHDATA1);
            append_script_byte(len[7:0]);
            put_payload(len);
        end
        else if (sel < 82)
        begin
            len = ($urandom_range(0, 49) == 0) ? $urandom_range(256, 600)
                                               : $urandom_range(0, 5);
            append_script_byte(OPC_PUSHDATA2);
            append_script_byte(len[7:0]);
            append_script_byte(len[15:8]);
            put_payload(len);
        end
        else
        begin
            len = $urandom_range(0, 5);
            append_script_byte(OPC_PUSHDATA4);
            for (int i = 0; i < 4; i++)
                append_script_byte(len[8*i +: 8]);
            put_payload(len);
        end
    endtask

    // a push cut short: inside its length field or inside its payload
    task automatic put_truncated_push();
        int          sel;
        int          n;
        int          k;
        logic [31:0] raw;
        sel = $urandom_range(0, 3);
        raw = $urandom;
        if (sel == 0)
        begin
            n = $urandom_range(1, 75);
            append_script_byte(8'(n));
            put_payload($urandom_range(0, n - 1));
        end
        else if (sel == 1)
        begin
            n = $urandom_range(1, 255);
            append_script_byte(OPC_PUSHDATA1);
            if ($urandom_range(0, 1) == 1)
            begin
                append_script_byte(8'(n));
                put_payload($urandom_range(0, (n < 4) ? n - 1 : 3));
            end
        end
        else
        begin
            // wide length from raw bits so every length bit toggles
            n = (sel == 2) ? 2 : 4;
            append_script_byte((sel == 2) ? OPC_PUSHDATA2 : OPC_PUSHDATA4);
            k = $urandom_range(0, n);
            for (int i = 0; i < k; i++)
                append_script_byte(raw[8*i +: 8]);
            if (k == n)
                put_payload($urandom_range(0, 3));
        end
    endtask

    // mostly well-formed scripts, some broken ones, some pure noise
    task automatic build_script();
        int kind;
        int ops;
        script_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 85)
        begin
            repeat ($urandom_range(1, 10)) append_script_byte(8'($urandom));
            return;
        end
        ops = (kind < 70) ? $urandom_range(1, 6) : $urandom_range(0, 2);
        repeat (ops) put_wellformed_op();
        if (kind >= 70)
            put_truncated_push();
    endtask

    // ------------------------------------------------------------------
    // directed rows: reset target 0xbb
    // ------------------------------------------------------------------
    typedef struct packed
    {
        logic [BYTE_W-1:0] code;
        logic              last;
        logic              fixed;
        verdict_t          want;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 25;

    directed_row_t directed_rows[DIRECTED_ROWS] = '{
        // one-byte scripts, verdicts read off directly
        '{8'hBB, 1'b1, 1'b1, VERDICT_FOUND},
        '{8'h00, 1'b1, 1'b1, VERDICT_ABSENT},
        '{8'hFF, 1'b1, 1'b1, VERDICT_ABSENT},
        '{8'h01, 1'b1, 1'b1, VERDICT_MALFORMED},
        '{8'h4C, 1'b1, 1'b1, VERDICT_MALFORMED},
        '{8'h4D, 1'b1, 1'b1, VERDICT_MALFORMED},
        '{8'h4E, 1'b1, 1'b1, VERDICT_MALFORMED},
        // pushdata2 of zero length
        '{8'h4D, 1'b0, 1'b0, VERDICT_FOUND},
        '{8'h00, 1'b0, 1'b0, VERDICT_FOUND},
        '{8'h00, 1'b1, 1'b0, VERDICT_FOUND},
        // pushdata4 of one byte, script ends on the payload byte
        '{8'h4E, 1'b0, 1'b0, VERDICT_FOUND},
        '{8'h01, 1'b0, 1'b0, VERDICT_FOUND},
        '{8'h00, 1'b0, 1'b0, VERDICT_FOUND},
        '{8'h00, 1'b0, 1'b0, VERDICT_FOUND},
        '{8'h00, 1'b0, 1'b0, VERDICT_FOUND},
        '{8'h61, 1'b1, 1'b0, VERDICT_FOUND},
        // found, then cut inside a payload: malformed wins
        '{8'hBB, 1'b0, 1'b1, VERDICT_MALFORMED},
        '{8'h02, 1'b0, 1'b1, VERDICT_MALFORMED},
        '{8'hAA, 1'b1, 1'b1, VERDICT_MALFORMED},
        // target hidden in a payload
        '{8'h01, 1'b0, 1'b0, VERDICT_FOUND},
        '{8'hBB, 1'b0, 1'b0, VERDICT_FOUND},
        '{8'h51, 1'b1, 1'b0, VERDICT_FOUND},
        // zero-length pushdata1, then the target as an opcode
        '{8'h4C, 1'b0, 1'b0, VERDICT_FOUND},
        '{8'h00, 1'b0, 1'b0, VERDICT_FOUND},
        '{8'hBB, 1'b1, 1'b0, VERDICT_FOUND}
    };

    // targets per random phase: extremes, every PUSHDATA opcode, the largest direct push, one random, the reset target
    logic [BYTE_W-1:0] phase_targets[8] = '{8'h00, 8'hFF, 8'h4C, 8'h4D,
                                            8'h4E, 8'h4B, 8'h00, 8'hBB};

    // ------------------------------------------------------------------
    // output side: ready pattern with one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : verdict_sink
        int  stall;
        bit  held_off;
        held_off = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held_off && beats_taken >= HOLD_AFTER)
            begin
                // long hold-off so the output register fills and input stalls
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = pick_gap();
                if (stall == 0)
                begin
                    m_tready <= 1'b1;
                    @(posedge clk);
                end
                else
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // verdict checking
    // ------------------------------------------------------------------
    int mismatches = 0;

    always @(posedge clk)
    begin : verdict_check
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdicts_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("unexpected verdict beat: got %02h", m_tdata);
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (m_tdata !== {6'd0, want})
                begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("verdict mismatch: expected %02h got %02h",
                                 {6'd0, want}, m_tdata);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // run limit
    // ------------------------------------------------------------------
    initial
    begin : run_limit
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL script_opcode_scanner");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        int beats_at_start;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows on the reset target
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_script_byte(directed_rows[i].code, directed_rows[i].last,
                             directed_rows[i].fixed, directed_rows[i].want);

        // random phases, one target each, every third phase without gaps
        phase_targets[6] = 8'($urandom);
        for (int p = 0; p < 8; p++)
        begin
            write_target(phase_targets[p]);
            no_gaps        = (p % 3 == 1);
            beats_at_start = beats_taken;
            while (beats_taken - beats_at_start < PHASE_BEATS)
            begin
                build_script();
                for (int i = 0; i < script_bytes.size(); i++)
                    send_script_byte(script_bytes[i], i == script_bytes.size() - 1,
                                     1'b0, VERDICT_FOUND);
            end
        end

        // drain
        s_tvalid <= 1'b0;
        no_gaps   = 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("PASS script_opcode_scanner");
        else
            $display("FAIL script_opcode_scanner");
        $finish;
    end

endmodule
